### design/exp_power_hyperelastic_eval_unit_defines.svh
// Assertion macros shared by the exponential-power evaluator RTL
`ifndef EXP_POWER_HYPERELASTIC_EVAL_UNIT_DEFINES_SVH
`define EXP_POWER_HYPERELASTIC_EVAL_UNIT_DEFINES_SVH

// Implication checked in the same cycle, held off during reset
`define EPHE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the cycle after the antecedent, held off during reset
`define EPHE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/ephe_pkg.sv
// Shared types, constants and fixed-point helpers of the exponential-power evaluator
package ephe_pkg;

    localparam int FRAC_BITS  = 16;
    localparam int POW_CELLS  = 28;   // highest power needed is 2*15-2
    localparam int TERM_CELLS = 12;   // series terms of 2^f
    localparam int DIV_CELLS  = 32;   // quotient bits of the energy divide

    localparam logic signed [31:0] FX_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] FX_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] FX_ONE = 32'(64'sd1 <<< FRAC_BITS);

    localparam logic signed [63:0] LOG2E_Q30 = 64'sd1549082005;
    localparam logic [29:0]        LN2_Q30   = 30'd744261118;
    localparam logic [30:0]        ONE_Q30   = 31'd1073741824;

    typedef enum logic [1:0] {
        REG_STIFFNESS = 2'd0,
        REG_RATE      = 2'd1,
        REG_EXPONENT  = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } fx_t;

    // power chain bus
    typedef struct packed {
        logic               valid;
        logic signed [31:0] x;
        logic signed [31:0] p;
        logic signed [31:0] pd;
        logic signed [31:0] pdm1;
        logic signed [31:0] pdm2;
        logic signed [31:0] p2d2;
        logic               sat;
    } pow_bus_t;

    // exponential series bus
    typedef struct packed {
        logic               valid;
        logic [30:0]        term;
        logic [31:0]        s;
        logic [29:0]        y;
        logic signed [32:0] n;
        logic signed [31:0] g1;
        logic signed [31:0] inner;
        logic               sat;
        logic               dsat;
    } exp_bus_t;

    // divider bus
    typedef struct packed {
        logic               valid;
        logic [32:0]        rem;
        logic [31:0]        nlo;
        logic [31:0]        q;
        logic [32:0]        dmag;
        logic               neg;
        logic               ovf;
        logic               ezero;
        logic signed [31:0] d1;
        logic signed [31:0] d2;
        logic               err;
        logic               sat;
    } div_bus_t;

    // clip to the signed 32-bit range
    function automatic fx_t sat32(input logic signed [63:0] v);
        fx_t r;
        if (v > 64'(FX_MAX)) begin
            r.val = FX_MAX;
            r.ovf = 1'b1;
        end else if (v < 64'(FX_MIN)) begin
            r.val = FX_MIN;
            r.ovf = 1'b1;
        end else begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // fixed-point product, round to nearest with ties up, clipped
    function automatic fx_t fmul(input logic signed [31:0] a, input logic signed [31:0] b);
        logic signed [63:0] prod;
        logic signed [63:0] rnd;
        prod = 64'(a) * 64'(b);
        rnd  = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return sat32(rnd);
    endfunction

    // floor(2^32 / k) for the series divisors
    function automatic logic [32:0] recip(input logic [3:0] k);
        logic [32:0] r;
        case (k)
            4'd1:    r = 33'd4294967296;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

### design/ephe_pow_cell.sv
// One step of the power chain: multiplies the running power by x and taps needed powers
module ephe_pow_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [4:0]        cell_idx,
    input  logic [3:0]        d,
    input  ephe_pkg::pow_bus_t in_bus,
    output ephe_pkg::pow_bus_t out_bus
);
    import ephe_pkg::*;

    pow_bus_t   bus_next;
    pow_bus_t   bus_reg;
    logic       valid_reg;
    fx_t        step;
    logic [4:0] d5;
    logic [4:0] lim;

    // next power and taps
    always_comb begin
        d5   = {1'b0, d};
        lim  = (d >= 4'd2) ? ((d5 << 1) - 5'd2) : d5;
        step = fmul(in_bus.p, in_bus.x);
        bus_next   = in_bus;
        bus_next.p = step.val;
        if (cell_idx <= lim) begin
            bus_next.sat = in_bus.sat | step.ovf;
        end
        if (cell_idx == d5) begin
            bus_next.pd = step.val;
        end
        if (cell_idx == d5 - 5'd1) begin
            bus_next.pdm1 = step.val;
        end
        if (cell_idx == d5 - 5'd2) begin
            bus_next.pdm2 = step.val;
        end
        if (cell_idx == (d5 << 1) - 5'd2) begin
            bus_next.p2d2 = step.val;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_bus.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bus_reg <= bus_next;
        end
    end

    always_comb begin
        out_bus       = bus_reg;
        out_bus.valid = valid_reg;
    end

endmodule

### design/ephe_exp_cell.sv
// One series term of 2^f: term = round(term*y)/k, sum += term, over three stages
module ephe_exp_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  logic [3:0]        term_idx,
    input  ephe_pkg::exp_bus_t in_bus,
    output ephe_pkg::exp_bus_t out_bus
);
    import ephe_pkg::*;

    logic [2:0]  vld_reg;
    exp_bus_t    a_bus_reg;
    exp_bus_t    b_bus_reg;
    exp_bus_t    c_bus_reg;
    exp_bus_t    c_bus_next;
    logic [60:0] prod_reg;
    logic [30:0] v_reg;
    logic [30:0] v_next;
    logic [63:0] qa_reg;
    logic [31:0] q0;
    logic [31:0] q;
    logic [35:0] rsd;

    // stage B: round the product and scale by the reciprocal
    always_comb begin
        v_next = 31'((prod_reg + 61'd536870912) >> 30);
    end

    // stage C: fix the quotient by one and add the term
    always_comb begin
        q0  = qa_reg[63:32];
        rsd = 36'(v_reg) - 36'(q0) * 36'(term_idx);
        q   = (rsd >= 36'(term_idx)) ? q0 + 32'd1 : q0;
        c_bus_next      = b_bus_reg;
        c_bus_next.term = q[30:0];
        c_bus_next.s    = b_bus_reg.s + q;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 3'b000;
        end else if (adv) begin
            vld_reg <= {vld_reg[1:0], in_bus.valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_bus_reg <= in_bus;
            prod_reg  <= 61'(in_bus.term) * 61'(in_bus.y);
            b_bus_reg <= a_bus_reg;
            v_reg     <= v_next;
            qa_reg    <= 64'(v_next) * 64'(recip(term_idx));
            c_bus_reg <= c_bus_next;
        end
    end

    always_comb begin
        out_bus       = c_bus_reg;
        out_bus.valid = vld_reg[2];
    end

endmodule

### design/ephe_div_cell.sv
// One restoring-division step: shifts in a dividend bit and produces one quotient bit
module ephe_div_cell (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              adv,
    input  ephe_pkg::div_bus_t in_bus,
    output ephe_pkg::div_bus_t out_bus
);
    import ephe_pkg::*;

    div_bus_t    bus_next;
    div_bus_t    bus_reg;
    logic        valid_reg;
    logic [33:0] trial;

    always_comb begin
        trial    = {in_bus.rem, in_bus.nlo[31]};
        bus_next = in_bus;
        bus_next.nlo = in_bus.nlo << 1;
        if (trial >= {1'b0, in_bus.dmag}) begin
            bus_next.rem = 33'(trial - {1'b0, in_bus.dmag});
            bus_next.q   = {in_bus.q[30:0], 1'b1};
        end else begin
            bus_next.rem = trial[32:0];
            bus_next.q   = {in_bus.q[30:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (adv) begin
            valid_reg <= in_bus.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            bus_reg <= bus_next;
        end
    end

    always_comb begin
        out_bus       = bus_reg;
        out_bus.valid = valid_reg;
    end

endmodule

### design/exp_power_hyperelastic_eval_unit.sv
// Top level of the exponential-power strain energy evaluator
//
// Input stream: s_tdata carries one modified first invariant I (Q16.16) per
// transfer. Output stream: m_tdata carries energy, first and second derivative
// (Q16.16), m_tuser carries the exponent error and saturation flags.
// Registers k1, k2 and d are written through the cfg_* port; the user must
// write them only while idle, which the block does not enforce. Each input
// passes 1 input stage, 28 power cells, 3 exponent prep stages, 12 series
// cells of 3 stages, 4 derivative stages, 32 divider cells and the output
// register. Throughput is one item per cycle while not stalled; a stage
// holds at most three 32x32 multipliers side by side, never two in a row.
// Reset clears all valid bits and loads k1 = 1.0, k2 = 1.0, d = 1.
// When the receiver stalls with a result waiting, the pipeline still moves
// while its last stage is empty; once that stage holds an item the whole
// pipeline and s_tready hold until the output transfer.
module exp_power_hyperelastic_eval_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,    // [31:0] modified_invariant
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata,    // [31:0] energy_increment, [63:32] first_derivative,
                                    // [95:64] second_derivative
    output logic [1:0]  m_tuser,    // [0] exponent_error, [1] saturated
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);
    import ephe_pkg::*;

    `include "exp_power_hyperelastic_eval_unit_defines.svh"

    // configuration
    logic signed [31:0] k1_reg;
    logic signed [31:0] k2_reg;
    logic [3:0]         d_reg;
    logic signed [63:0] d_s;

    // flow control
    logic adv;
    logic out_load;

    // buses
    pow_bus_t pw_bus [0:POW_CELLS];
    exp_bus_t ex_bus [0:TERM_CELLS];
    div_bus_t dv_bus [0:DIV_CELLS];

    // input stage
    pow_bus_t s0_next;
    pow_bus_t s0_reg;
    logic     s0_vld_reg;
    fx_t      x_fx;

    // E1..E3
    logic               e1_vld_reg, e2_vld_reg, e3_vld_reg;
    fx_t                t_fx, i1_fx;
    logic signed [31:0] t_reg, i1_reg, g1_e1_reg, pdm2_reg;
    logic               sat_e1_reg, dsat_e1_reg;
    logic signed [63:0] u_full, inner_raw;
    fx_t                inner_fx;
    logic signed [32:0] u_reg;
    logic signed [31:0] inner_e2_reg, g1_e2_reg;
    logic               sat_e2_reg, dsat_e2_reg;
    exp_bus_t           e3_next, e3_reg;
    logic [29:0]        y_next;

    // X1..X4
    logic               x1_vld_reg, x2_vld_reg, x3_vld_reg, x4_vld_reg;
    logic signed [33:0] sh;
    logic [33:0]        rsh;
    logic [63:0]        wide;
    fx_t                e_fx;
    logic signed [31:0] e_reg, g1_x1_reg, inner_x1_reg;
    logic               sat_x1_reg, dsat_x1_reg;
    fx_t                a_fx, b_fx;
    logic signed [63:0] num_reg;
    logic signed [31:0] a_reg, b_reg;
    logic               sat_x2_reg, dsat_x2_reg;
    fx_t                m1_fx, m2_fx;
    logic signed [31:0] m1_reg, m2_reg;
    logic [63:0]        nmag_reg;
    logic               nneg_reg, sat_x3_reg, dsat_x3_reg;
    fx_t                d1_fx, d2_fx;
    logic signed [32:0] den_s;
    div_bus_t           x4_next, x4_reg;

    // output
    div_bus_t           fin;
    logic signed [31:0] energy;
    logic               energy_sat;
    logic signed [32:0] qs;
    logic [95:0]        m_tdata_reg;
    logic [1:0]         m_tuser_reg;
    logic               m_tvalid_reg;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k1_reg <= FX_ONE;
            k2_reg <= FX_ONE;
            d_reg  <= 4'd1;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_STIFFNESS: k1_reg <= cfg_wdata;
                REG_RATE:      k2_reg <= cfg_wdata;
                REG_EXPONENT:  d_reg  <= cfg_wdata[3:0];
                default: ;
            endcase
        end
    end

    assign d_s = $signed({60'd0, d_reg});

    // pipeline moves unless a finished item is blocked
    assign out_load = !m_tvalid_reg || m_tready;
    assign adv      = out_load || !fin.valid;
    assign s_tready = adv;

    // input stage: x = I - 3, clipped
    always_comb begin
        x_fx = sat32(64'($signed(s_tdata)) - 64'(3) * 64'(FX_ONE));
        s0_next       = '0;
        s0_next.valid = s_tvalid;
        s0_next.x     = x_fx.val;
        s0_next.p     = FX_ONE;
        s0_next.pd    = FX_ONE;
        s0_next.pdm1  = FX_ONE;
        s0_next.pdm2  = FX_ONE;
        s0_next.p2d2  = FX_ONE;
        s0_next.sat   = x_fx.ovf;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_vld_reg <= 1'b0;
        end else if (adv) begin
            s0_vld_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s0_reg <= s0_next;
        end
    end

    always_comb begin
        pw_bus[0]       = s0_reg;
        pw_bus[0].valid = s0_vld_reg;
    end

    // power chain
    for (genvar gi = 0; gi < POW_CELLS; gi++) begin : g_pow
        ephe_pow_cell u_pow_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .cell_idx (5'(gi + 1)),
            .d        (d_reg),
            .in_bus   (pw_bus[gi]),
            .out_bus  (pw_bus[gi + 1])
        );
    end

    // E1: exponent argument and k2 * x^(2d-2)
    always_comb begin
        t_fx  = fmul(k2_reg, pw_bus[POW_CELLS].pd);
        i1_fx = fmul(k2_reg, pw_bus[POW_CELLS].p2d2);
    end

    // E2: scale to base 2, form the bracket
    always_comb begin
        u_full    = (t_reg * LOG2E_Q30 + (64'sd1 <<< 29)) >>> 30;
        inner_raw = 64'(i1_reg) * d_s
                  + ((d_reg >= 4'd2) ? 64'(pdm2_reg) * (d_s - 64'sd1) : 64'sd0);
        inner_fx  = sat32(inner_raw);
    end

    // E3: split integer and fraction, fraction times ln2
    always_comb begin
        y_next = 30'(((60'(30'(u_reg[FRAC_BITS-1:0]) << (30 - FRAC_BITS)) * 60'(LN2_Q30))
                     + 60'd536870912) >> 30);
        e3_next       = '0;
        e3_next.valid = e2_vld_reg;
        e3_next.term  = ONE_Q30;
        e3_next.s     = 32'(ONE_Q30);
        e3_next.y     = y_next;
        e3_next.n     = u_reg >>> FRAC_BITS;
        e3_next.g1    = g1_e2_reg;
        e3_next.inner = inner_e2_reg;
        e3_next.sat   = sat_e2_reg;
        e3_next.dsat  = dsat_e2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
        end else if (adv) begin
            e1_vld_reg <= pw_bus[POW_CELLS].valid;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            t_reg        <= t_fx.val;
            i1_reg       <= i1_fx.val;
            g1_e1_reg    <= pw_bus[POW_CELLS].pdm1;
            pdm2_reg     <= pw_bus[POW_CELLS].pdm2;
            sat_e1_reg   <= pw_bus[POW_CELLS].sat | t_fx.ovf;
            dsat_e1_reg  <= i1_fx.ovf;
            u_reg        <= u_full[32:0];
            inner_e2_reg <= inner_fx.val;
            g1_e2_reg    <= g1_e1_reg;
            sat_e2_reg   <= sat_e1_reg;
            dsat_e2_reg  <= dsat_e1_reg | inner_fx.ovf;
            e3_reg       <= e3_next;
        end
    end

    always_comb begin
        ex_bus[0]       = e3_reg;
        ex_bus[0].valid = e3_vld_reg;
    end

    // series for 2^f
    for (genvar gk = 0; gk < TERM_CELLS; gk++) begin : g_term
        ephe_exp_cell u_exp_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .adv      (adv),
            .term_idx (4'(gk + 1)),
            .in_bus   (ex_bus[gk]),
            .out_bus  (ex_bus[gk + 1])
        );
    end

    // X1: scale the series sum by 2^n
    always_comb begin
        sh   = 34'(ex_bus[TERM_CELLS].n) + 34'(FRAC_BITS - 30);
        rsh  = 34'(-sh);
        wide = 64'd0;
        e_fx = '0;
        if (sh > 34'sd31) begin
            e_fx.val = FX_MAX;
            e_fx.ovf = 1'b1;
        end else if (sh >= 34'sd0) begin
            wide = 64'(ex_bus[TERM_CELLS].s) << sh[4:0];
            if (wide > 64'(FX_MAX)) begin
                e_fx.val = FX_MAX;
                e_fx.ovf = 1'b1;
            end else begin
                e_fx.val = wide[31:0];
            end
        end else if (rsh <= 34'd62) begin
            wide = (64'(ex_bus[TERM_CELLS].s) + (64'd1 << (rsh[5:0] - 6'd1))) >> rsh[5:0];
            e_fx.val = wide[31:0];
        end
    end

    // X2: energy numerator and e * g
    always_comb begin
        a_fx = fmul(e_reg, g1_x1_reg);
        b_fx = fmul(e_reg, inner_x1_reg);
    end

    // X3: multiply by k1, numerator magnitude
    always_comb begin
        m1_fx = fmul(k1_reg, a_reg);
        m2_fx = fmul(k1_reg, b_reg);
    end

    // X4: derivative scaling by d/2 and divider setup
    always_comb begin
        d1_fx = sat32((64'(m1_reg) * d_s + 64'sd1) >>> 1);
        d2_fx = sat32((64'(m2_reg) * d_s + 64'sd1) >>> 1);
        den_s = {k2_reg, 1'b0};
        x4_next       = '0;
        x4_next.valid = x3_vld_reg;
        x4_next.dmag  = k2_reg[31] ? 33'(-den_s) : 33'(den_s);
        x4_next.rem   = {1'b0, nmag_reg[63:32]};
        x4_next.nlo   = nmag_reg[31:0];
        x4_next.q     = 32'd0;
        x4_next.neg   = nneg_reg ^ k2_reg[31];
        x4_next.ovf   = !({1'b0, nmag_reg[63:32]} < x4_next.dmag);
        x4_next.ezero = (k2_reg == 32'sd0);
        x4_next.err   = (d_reg == 4'd0);
        if (d_reg != 4'd0) begin
            x4_next.d1  = d1_fx.val;
            x4_next.d2  = d2_fx.val;
            x4_next.sat = sat_x3_reg | dsat_x3_reg | d1_fx.ovf | d2_fx.ovf;
        end else begin
            x4_next.d1  = 32'sd0;
            x4_next.d2  = 32'sd0;
            x4_next.sat = sat_x3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_vld_reg <= 1'b0;
            x2_vld_reg <= 1'b0;
            x3_vld_reg <= 1'b0;
            x4_vld_reg <= 1'b0;
        end else if (adv) begin
            x1_vld_reg <= ex_bus[TERM_CELLS].valid;
            x2_vld_reg <= x1_vld_reg;
            x3_vld_reg <= x2_vld_reg;
            x4_vld_reg <= x3_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e_reg        <= e_fx.val;
            g1_x1_reg    <= ex_bus[TERM_CELLS].g1;
            inner_x1_reg <= ex_bus[TERM_CELLS].inner;
            sat_x1_reg   <= ex_bus[TERM_CELLS].sat | e_fx.ovf;
            dsat_x1_reg  <= ex_bus[TERM_CELLS].dsat;
            num_reg      <= 64'(k1_reg) * (64'(e_reg) - 64'(FX_ONE));
            a_reg        <= a_fx.val;
            b_reg        <= b_fx.val;
            sat_x2_reg   <= sat_x1_reg;
            dsat_x2_reg  <= dsat_x1_reg | a_fx.ovf | b_fx.ovf;
            m1_reg       <= m1_fx.val;
            m2_reg       <= m2_fx.val;
            nmag_reg     <= num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
            nneg_reg     <= num_reg[63];
            sat_x3_reg   <= sat_x2_reg;
            dsat_x3_reg  <= dsat_x2_reg | m1_fx.ovf | m2_fx.ovf;
            x4_reg       <= x4_next;
        end
    end

    always_comb begin
        dv_bus[0]       = x4_reg;
        dv_bus[0].valid = x4_vld_reg;
    end

    // energy divide, one quotient bit per cell
    for (genvar gq = 0; gq < DIV_CELLS; gq++) begin : g_div
        ephe_div_cell u_div_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .adv     (adv),
            .in_bus  (dv_bus[gq]),
            .out_bus (dv_bus[gq + 1])
        );
    end

    // sign and clip the quotient
    always_comb begin
        fin        = dv_bus[DIV_CELLS];
        energy     = 32'sd0;
        energy_sat = 1'b0;
        qs         = fin.neg ? -$signed({1'b0, fin.q}) : $signed({1'b0, fin.q});
        if (fin.ezero) begin
            energy = 32'sd0;
        end else if (fin.ovf) begin
            energy     = fin.neg ? FX_MIN : FX_MAX;
            energy_sat = 1'b1;
        end else if (qs > 33'(FX_MAX)) begin
            energy     = FX_MAX;
            energy_sat = 1'b1;
        end else if (qs < 33'(FX_MIN)) begin
            energy     = FX_MIN;
            energy_sat = 1'b1;
        end else begin
            energy = qs[31:0];
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= fin.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_tdata_reg <= {fin.d2, fin.d1, energy};
            m_tuser_reg <= {fin.sat | energy_sat, fin.err};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // checks
    `EPHE_ASSERT_NOW(a_err_zero_deriv, m_tvalid && m_tuser[0],
        (m_tdata[63:32] == 32'd0) && (m_tdata[95:64] == 32'd0),
        "derivatives nonzero with exponent error")
    `EPHE_ASSERT_NOW(a_ready_only_on_block, !s_tready, m_tvalid && !m_tready,
        "input held without a blocked output")
    `EPHE_ASSERT_NEXT(a_zero_rate_energy, s_tready && (k2_reg == 32'sd0) && !cfg_wr_en,
        !m_tvalid || (k2_reg != 32'sd0) || (m_tdata[31:0] == 32'd0),
        "energy nonzero with zero rate")

endmodule

### bench/tb_exp_power_hyperelastic_eval_unit.sv
// Self-checking testbench for the exponential-power strain energy evaluator
module tb_exp_power_hyperelastic_eval_unit;
    import ephe_pkg::*;

    localparam int LATENCY     = 105;
    localparam int N_RANDOM    = 1850;
    localparam int CYCLE_LIMIT = 400000;

    typedef struct packed {
        logic               sat;
        logic               err;
        logic signed [31:0] d2;
        logic signed [31:0] d1;
        logic signed [31:0] energy;
    } energy_result_t;

    typedef struct {
        logic [31:0]    inv;
        logic           known;
        energy_result_t res;
    } stim_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;

    // predictor copy of the registers
    logic signed [63:0] k1_q = 64'sd65536;
    logic signed [63:0] k2_q = 64'sd65536;
    int unsigned        dexp_q = 1;

    energy_result_t expected_results[$];
    int  errors = 0;
    int  cycles = 0;
    bit  allow_idle = 1'b1;

    exp_power_hyperelastic_eval_unit u_dut (.*);

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("exp_power_hyperelastic_eval_unit verification failed");
            $finish;
        end
    end

    // ---------------- predictor ----------------
    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] round_shift(logic signed [63:0] v, int s);
        return (v + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic logic signed [63:0] clip32(logic signed [63:0] v, ref bit f);
        if (v > 64'sd2147483647) begin
            f = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            f = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b,
                                                ref bit f);
        return clip32(round_shift(a * b, FRAC_BITS), f);
    endfunction

    function automatic logic signed [63:0] qpow(logic signed [63:0] x, int n, ref bit f);
        logic signed [63:0] p;
        p = 64'sd1 <<< FRAC_BITS;
        for (int i = 0; i < n; i++) p = qmul(p, x, f);
        return p;
    endfunction

    function automatic logic signed [63:0] qexp(logic signed [63:0] t, ref bit f);
        logic signed [63:0] u, n, fr, sh;
        logic [63:0] y, s, term;
        u  = round_shift(t * 64'sd1549082005, 30);
        n  = floor_shift(u, FRAC_BITS);
        fr = u - (n <<< FRAC_BITS);
        y  = (((64'(fr) << (30 - FRAC_BITS)) * 64'd744261118) + (64'd1 << 29)) >> 30;
        s = 64'd1073741824;
        term = s;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * y + (64'd1 << 29)) >> 30) / k;
            s += term;
        end
        sh = n + FRAC_BITS - 30;
        if (sh >= 0) begin
            if (sh > 31) begin
                f = 1;
                return 64'sd2147483647;
            end
            return clip32($signed(s << sh), f);
        end
        if (-sh > 62) return 64'sd0;
        return $signed((s + (64'd1 << (-sh - 1))) >> (-sh));
    endfunction

    function automatic energy_result_t predict_energy(logic [31:0] inv);
        energy_result_t r;
        bit f;
        logic signed [63:0] one, x, e, g, inner, m;
        f = 0;
        one = 64'sd1 <<< FRAC_BITS;
        x = clip32(64'($signed(inv)) - 3 * one, f);
        e = qexp(qmul(k2_q, qpow(x, dexp_q, f), f), f);
        r = '0;
        if (k2_q != 0) r.energy = 32'(clip32((k1_q * (e - one)) / (2 * k2_q), f));
        if (dexp_q >= 1) begin
            g = qpow(x, dexp_q - 1, f);
            m = qmul(k1_q, qmul(e, g, f), f);
            r.d1 = 32'(clip32(round_shift(m * dexp_q, 1), f));
            inner = qmul(k2_q, qpow(x, 2 * dexp_q - 2, f), f) * dexp_q;
            if (dexp_q >= 2) inner += (dexp_q - 1) * qpow(x, dexp_q - 2, f);
            inner = clip32(inner, f);
            m = qmul(k1_q, qmul(e, inner, f), f);
            r.d2 = 32'(clip32(round_shift(m * dexp_q, 1), f));
        end
        r.err = (dexp_q < 1);
        r.sat = f;
        return r;
    endfunction

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        energy_result_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tuser[1], m_tuser[0], m_tdata[95:64], m_tdata[63:32], m_tdata[31:0]};
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer");
                errors++;
            end else begin
                want = expected_results.pop_front();
                if (got.energy !== want.energy) begin
                    $error("energy_increment exp %0d got %0d", want.energy, got.energy);
                    errors++;
                end
                if (got.d1 !== want.d1) begin
                    $error("first_derivative exp %0d got %0d", want.d1, got.d1);
                    errors++;
                end
                if (got.d2 !== want.d2) begin
                    $error("second_derivative exp %0d got %0d", want.d2, got.d2);
                    errors++;
                end
                if (got.err !== want.err) begin
                    $error("exponent_error exp %0b got %0b", want.err, got.err);
                    errors++;
                end
                if (got.sat !== want.sat) begin
                    $error("saturated exp %0b got %0b", want.sat, got.sat);
                    errors++;
                end
            end
        end
    end

    // receiver stalls in random bursts
    always @(negedge aclk) begin
        int stall;
        if (allow_idle && $urandom_range(0, 5) == 0) begin
            stall = $urandom_range(1, 3);
            m_tready <= 1'b0;
            repeat (stall) @(negedge aclk);
        end
        m_tready <= 1'b1;
    end

    // ---------------- driver tasks ----------------
    task automatic write_reg(cfg_reg_t idx, logic [31:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_STIFFNESS: k1_q = 64'($signed(val));
            REG_RATE:      k2_q = 64'($signed(val));
            default:       dexp_q = val[3:0];
        endcase
    endtask

    // drive one invariant; the line is at a falling edge on entry and exit
    task automatic send_invariant(logic [31:0] inv, bit known, energy_result_t res);
        energy_result_t p;
        if (allow_idle && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= inv;
        p = predict_energy(inv);
        if (known && p !== res) begin
            $error("directed row for invariant %h disagrees with predictor", inv);
            errors++;
        end
        do @(posedge aclk); while (!s_tready);
        expected_results.push_back(known ? res : p);
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge aclk);
        repeat (LATENCY + 10) @(negedge aclk);
    endtask

    function automatic logic [31:0] rand_invariant();
        case ($urandom_range(0, 5))
            0:       return $urandom();
            1:       return 32'h0003_0000 + $urandom_range(0, 32'h0000_FFFF) - 32'h8000;
            default: return 32'h0003_0000 + $urandom_range(0, 32'h0003_0000);
        endcase
    endfunction

    // ---------------- stimulus ----------------
    stim_row_t directed[$];

    initial begin
        int d_choice[] = '{0, 1, 2, 3, 15};
        // invariant 3.0 with reset registers: x = 0, e = 1
        directed.push_back('{32'h0003_0000, 1, '{sat: 0, err: 0, d2: 32'sh0000_8000,
                             d1: 32'sh0000_8000, energy: 0}});
        directed.push_back('{32'h7FFF_FFFF, 0, '0});
        directed.push_back('{32'h8000_0000, 0, '0});
        directed.push_back('{32'h0000_0000, 0, '0});
        directed.push_back('{32'hFFFF_FFFF, 0, '0});
        directed.push_back('{32'h0003_8000, 0, '0});
        directed.push_back('{32'h0004_0000, 0, '0});
        directed.push_back('{32'h0002_0000, 0, '0});
        directed.push_back('{32'h0005_4321, 0, '0});
        directed.push_back('{32'h0003_0001, 0, '0});

        repeat (8) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed[i]) send_invariant(directed[i].inv, directed[i].known, directed[i].res);
        drain();

        // zero exponent flags the error, zero rate clears the energy
        write_reg(REG_EXPONENT, 32'd0);
        send_invariant(32'h0004_0000, 0, '0);
        send_invariant(32'h7FFF_FFFF, 0, '0);
        drain();
        write_reg(REG_EXPONENT, 32'd2);
        write_reg(REG_RATE, 32'd0);
        send_invariant(32'h0005_0000, 0, '0);
        send_invariant(32'h8000_0000, 0, '0);
        drain();
        write_reg(REG_RATE, 32'h8000_0000);
        write_reg(REG_STIFFNESS, 32'h7FFF_FFFF);
        send_invariant(32'h0004_0000, 0, '0);
        drain();
        write_reg(REG_STIFFNESS, 32'h8000_0000);
        write_reg(REG_RATE, 32'h7FFF_FFFF);
        write_reg(REG_EXPONENT, 32'd15);
        send_invariant(32'h0003_1000, 0, '0);
        send_invariant(32'h0004_0000, 0, '0);
        drain();

        // random phases, each under its own register setting
        for (int ph = 0; ph < 10; ph++) begin
            write_reg(REG_STIFFNESS, (ph % 3 == 0) ? $urandom()
                                     : $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            write_reg(REG_RATE, (ph % 4 == 0) ? $urandom()
                                : $urandom_range(0, 32'h0002_0000) - 32'h0001_0000);
            write_reg(REG_EXPONENT, (ph % 2 == 0) ? d_choice[$urandom_range(0, 4)]
                                    : $urandom_range(0, 15));
            if (ph == 9) allow_idle = 1'b0;
            for (int i = 0; i < N_RANDOM / 10; i++) begin
                send_invariant(rand_invariant(), 0, '0);
                // sender pause until everything is back
                if (ph == 4 && i == 50) begin
                    s_tvalid <= 1'b0;
                    while (expected_results.size() != 0) @(negedge aclk);
                end
            end
            drain();
        end

        if (errors == 0) begin
            $display("exp_power_hyperelastic_eval_unit verification clean");
        end else begin
            $display("exp_power_hyperelastic_eval_unit verification failed");
        end
        $finish;
    end

endmodule
